[rtl/torus_vertex_generator_unit_assert.svh]
// ----------------------------------------------------------------------------
// torus vertex generator assertion macros
// shared concurrent assertion forms, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef TORUS_VERTEX_GENERATOR_UNIT_ASSERT_SVH
`define TORUS_VERTEX_GENERATOR_UNIT_ASSERT_SVH

// condition and consequence in the same cycle
`define TVG_ASSERT_SAME(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// consequence in the cycle after the condition
`define TVG_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

[rtl/tvg_pkg.sv]
// ----------------------------------------------------------------------------
// tvg_pkg
// shared constants, types and helpers of the torus vertex generator
// ----------------------------------------------------------------------------
package tvg_pkg;

   // defaults of the top level parameters
   localparam int INDEX_BITS_DEF     = 12;
   localparam int TRIG_FRAC_BITS_DEF = 14;

   // divider and cordic organization
   localparam int QUOT_BITS        = 34;
   localparam int DIV_PER_STAGE    = 3;
   localparam int PHASE_BITS       = 32;
   localparam int CORDIC_ITERS     = 24;
   localparam int CORDIC_PER_STAGE = 2;
   localparam int CORDIC_W         = 34;
   localparam int CORDIC_FRAC      = 30;

   // field widths
   localparam int RADIUS_BITS    = 16;
   localparam int TEX_BITS       = 17;
   localparam int POS_BITS       = 18;
   localparam int NORM_BITS      = 16;
   localparam int NORM_FRAC      = 14;
   localparam int POS_FRAC       = 8;
   localparam int CSR_INDEX_BITS = 4;

   // gain-compensated cordic start value
   localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032875;

   // arctangent of 2^-k as a fraction of a turn, 2^32 scale
   localparam logic [CORDIC_FRAC-1:0] ATAN_TURNS [CORDIC_ITERS] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
      30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
   };

   // configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MAJOR_SEGMENTS = 4'd0,
      CSR_MINOR_SEGMENTS = 4'd1,
      CSR_MAJOR_RADIUS   = 4'd2,
      CSR_MINOR_RADIUS   = 4'd3
   } tvg_csr_index_type;

   // per-vertex data carried alongside the trig pipeline
   typedef struct packed {
      logic                second_vertex;
      logic [TEX_BITS-1:0] tex_s;
      logic [TEX_BITS-1:0] tex_t;
   } tvg_side_type;

   // result vertex, last field in the lowest bits
   typedef struct packed {
      logic        [TEX_BITS-1:0]  tex_t;
      logic        [TEX_BITS-1:0]  tex_s;
      logic signed [NORM_BITS-1:0] norm_z;
      logic signed [NORM_BITS-1:0] norm_y;
      logic signed [NORM_BITS-1:0] norm_x;
      logic signed [POS_BITS-1:0]  pos_z;
      logic signed [POS_BITS-1:0]  pos_y;
      logic signed [POS_BITS-1:0]  pos_x;
   } tvg_vertex_type;

   localparam int RSP_DATA_BITS = $bits(tvg_vertex_type);

   // saturate to the signed Q9.8 position range
   function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [63:0] v);
      logic signed [POS_BITS-1:0] r;
      if (v > 64'sd131071)       r = 18'sd131071;
      else if (v < -64'sd131072) r = -18'sd131072;
      else                       r = v[POS_BITS-1:0];
      return r;
   endfunction

   // clamp to plus or minus one in Q1.14
   function automatic logic signed [NORM_BITS-1:0] sat_norm(input logic signed [63:0] v);
      logic signed [NORM_BITS-1:0] r;
      if (v > 64'sd16384)       r = 16'sd16384;
      else if (v < -64'sd16384) r = -16'sd16384;
      else                      r = v[NORM_BITS-1:0];
      return r;
   endfunction

endpackage

[rtl/torus_vertex_generator_unit.sv]
// ----------------------------------------------------------------------------
// torus_vertex_generator_unit
// parametric torus tessellation: one grid point in, two vertices out
//
//   channel  direction  handshake                contents
//   req      in         req_tvalid / req_tready  strip_index, column_index
//   rsp      out        rsp_tvalid / rsp_tready  vertex fields, tlast = ring 1
//   csr      in         csr_valid / csr_ready    register index and value
//
// one vertex leaves per cycle while the output is not stalled; the request
// channel is held off while the pair expander issues a point's ring 1 vertex
// 31 register stages: divider 12, cordic 14, vertex assembly 4, output 1; the
// ring 1 vertex follows the ring 0 vertex of the same grid point
// synchronous active-high reset clears valid bits and loads register defaults
// a stalled result sits in the output register, one more goes to a skid
// register, then the whole pipeline holds
// ----------------------------------------------------------------------------
`include "torus_vertex_generator_unit_assert.svh"

module torus_vertex_generator_unit #(
   parameter int INDEX_BITS     = tvg_pkg::INDEX_BITS_DEF,
   parameter int TRIG_FRAC_BITS = tvg_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // strip_index, column_index, zero pad
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((2*INDEX_BITS+8)/8)*8-1:0]      req_tdata,
   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_s, tex_t
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [tvg_pkg::RSP_DATA_BITS-1:0]      rsp_tdata,
   output logic                                   rsp_tlast,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tvg_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [((INDEX_BITS+1 > 16) ? INDEX_BITS+1 : 16)-1:0] csr_data
);
   import tvg_pkg::*;

   localparam int SEG_W = INDEX_BITS + 1;
   localparam int TW    = TRIG_FRAC_BITS + 2;
   localparam logic [QUOT_BITS-1:0] QUOT_MAX = QUOT_BITS'(64'd1 << (QUOT_BITS - 1));

   // configuration registers
   logic [SEG_W-1:0]       major_seg_ff, minor_seg_ff;
   logic [RADIUS_BITS-1:0] major_rad_ff, minor_rad_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         major_seg_ff <= SEG_W'(32);
         minor_seg_ff <= SEG_W'(16);
         major_rad_ff <= RADIUS_BITS'(512);
         minor_rad_ff <= RADIUS_BITS'(128);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MAJOR_SEGMENTS: major_seg_ff <= csr_data[SEG_W-1:0];
            CSR_MINOR_SEGMENTS: minor_seg_ff <= csr_data[SEG_W-1:0];
            CSR_MAJOR_RADIUS:   major_rad_ff <= csr_data[RADIUS_BITS-1:0];
            CSR_MINOR_RADIUS:   minor_rad_ff <= csr_data[RADIUS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // global advance, held only while the skid register is full
   logic ce;
   logic skid_valid_ff;
   assign ce = ~skid_valid_ff;

   // pair expander: ring 0 from the request, ring 1 from the held indexes after it
   logic             pending_ff, pending_in;
   logic [SEG_W-1:0] hold_i_ff, hold_i_in, hold_j_ff, hold_j_in;
   logic [SEG_W-1:0] m_eff, n_eff, i_req, j_req, i_clamp, j_clamp;
   logic             job_valid, job_ring;
   logic [SEG_W-1:0] job_num [2];
   logic [SEG_W-1:0] job_den [2];
   logic             req_fire;

   assign req_tready = ce & ~pending_ff;
   assign req_fire   = req_tvalid & req_tready;

   always_comb begin
      m_eff   = (major_seg_ff == '0) ? SEG_W'(1) : major_seg_ff;
      n_eff   = (minor_seg_ff == '0) ? SEG_W'(1) : minor_seg_ff;
      i_req   = {1'b0, req_tdata[INDEX_BITS-1:0]};
      j_req   = req_tdata[2*INDEX_BITS:INDEX_BITS];
      i_clamp = (i_req > m_eff - SEG_W'(1)) ? m_eff - SEG_W'(1) : i_req;
      j_clamp = (j_req > n_eff) ? n_eff : j_req;

      job_valid  = pending_ff | req_fire;
      job_ring   = pending_ff;
      job_num[0] = pending_ff ? hold_i_ff + SEG_W'(1) : i_clamp;
      job_num[1] = pending_ff ? hold_j_ff : j_clamp;
      job_den[0] = m_eff;
      job_den[1] = n_eff;

      pending_in = pending_ff;
      hold_i_in  = hold_i_ff;
      hold_j_in  = hold_j_ff;
      if (ce) begin
         if (pending_ff) begin
            pending_in = 1'b0;
         end else if (req_fire) begin
            pending_in = 1'b1;
            hold_i_in  = i_clamp;
            hold_j_in  = j_clamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_i_ff <= hold_i_in;
      hold_j_ff <= hold_j_in;
   end

   // angle fractions
   logic                 div_valid, div_ring;
   logic [QUOT_BITS-1:0] div_quot [2];

   tvg_divider #(
      .INDEX_BITS (INDEX_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (job_valid),
      .in_ring   (job_ring),
      .in_num    (job_num),
      .in_den    (job_den),
      .out_valid (div_valid),
      .out_ring  (div_ring),
      .out_quot  (div_quot)
   );

   // rounded phase in turns and texture coordinates from the quotients
   logic [PHASE_BITS-1:0] phase [2];
   tvg_side_type          cord_side_in;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         phase[l] = PHASE_BITS'(div_quot[l][QUOT_BITS-1:1] +
                                (QUOT_BITS-1)'(div_quot[l][0]));
      end
      cord_side_in.second_vertex = div_ring;
      cord_side_in.tex_s = TEX_BITS'(div_quot[0][QUOT_BITS-1:QUOT_BITS-TEX_BITS] +
                                     TEX_BITS'(div_quot[0][QUOT_BITS-TEX_BITS-1]));
      cord_side_in.tex_t = TEX_BITS'(div_quot[1][QUOT_BITS-1:QUOT_BITS-TEX_BITS] +
                                     TEX_BITS'(div_quot[1][QUOT_BITS-TEX_BITS-1]));
   end

   // sine and cosine of the major and minor angles
   logic                 cord_valid;
   tvg_side_type         cord_side;
   logic signed [TW-1:0] cord_cos [2];
   logic signed [TW-1:0] cord_sin [2];

   tvg_cordic #(
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (div_valid),
      .in_side   (cord_side_in),
      .in_phase  (phase),
      .out_valid (cord_valid),
      .out_side  (cord_side),
      .out_cos   (cord_cos),
      .out_sin   (cord_sin)
   );

   // vertex assembly
   logic           shade_valid, shade_last;
   tvg_vertex_type shade_vertex;

   tvg_shade #(
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_shade (
      .clock        (clock),
      .reset        (reset),
      .ce           (ce),
      .in_valid     (cord_valid),
      .in_side      (cord_side),
      .in_cu        (cord_cos[0]),
      .in_su        (cord_sin[0]),
      .in_cv        (cord_cos[1]),
      .in_sv        (cord_sin[1]),
      .major_radius (major_rad_ff),
      .minor_radius (minor_rad_ff),
      .out_valid    (shade_valid),
      .out_last     (shade_last),
      .out_vertex   (shade_vertex)
   );

   // output register with skid register
   logic           rsp_valid_ff, rsp_valid_in, skid_valid_in;
   logic           rsp_last_ff, rsp_last_in, skid_last_ff, skid_last_in;
   tvg_vertex_type rsp_data_ff, rsp_data_in, skid_data_ff, skid_data_in;
   logic           new_valid;

   assign new_valid = ce & shade_valid;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_last_in  = skid_last_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_last_in   = skid_last_ff;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = new_valid;
            rsp_last_in  = shade_last;
            rsp_data_in  = shade_vertex;
         end
      end else if (new_valid) begin
         skid_valid_in = 1'b1;
         skid_last_in  = shade_last;
         skid_data_in  = shade_vertex;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_last_ff  <= rsp_last_in;
      rsp_data_ff  <= rsp_data_in;
      skid_last_ff <= skid_last_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `TVG_ASSERT_SAME(a_skid_behind_out, skid_valid_ff, rsp_valid_ff, "skid full with output empty")
   `TVG_ASSERT_SAME(a_skid_fill, $rose(skid_valid_ff), $past(rsp_valid_ff && !rsp_tready), "skid filled without a stalled output")
   `TVG_ASSERT_NEXT(a_pair_second, req_tvalid && req_tready, pending_ff, "ring 1 transaction not scheduled")
   `TVG_ASSERT_SAME(a_quot_range, div_valid, div_quot[0] <= QUOT_MAX && div_quot[1] <= QUOT_MAX, "angle fraction above one turn")

endmodule

[rtl/tvg_divider.sv]
// ----------------------------------------------------------------------------
// tvg_divider
// pipelined restoring divider, two lanes: quotient floor(num * 2^33 / den)
// for num <= den, a few quotient bits per stage
// ----------------------------------------------------------------------------
module tvg_divider #(
   parameter int INDEX_BITS = tvg_pkg::INDEX_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           ce,
   input  logic                           in_valid,
   input  logic                           in_ring,
   input  logic [INDEX_BITS:0]            in_num [2],
   input  logic [INDEX_BITS:0]            in_den [2],
   output logic                           out_valid,
   output logic                           out_ring,
   output logic [tvg_pkg::QUOT_BITS-1:0]  out_quot [2]
);
   import tvg_pkg::*;

   localparam int NUM_W      = INDEX_BITS + 1;
   localparam int REM_W      = INDEX_BITS + 2;
   localparam int FRAC_STEPS = QUOT_BITS - 1;
   localparam int NSTG       = (FRAC_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

   logic [NSTG:0]          valid_ff;
   logic [NSTG:0]          ring_ff;
   logic [NUM_W-1:0]       rem_ff  [NSTG+1][2];
   logic [NUM_W-1:0]       rem_in  [NSTG+1][2];
   logic [NUM_W-1:0]       den_ff  [NSTG+1][2];
   logic [NUM_W-1:0]       den_in  [NSTG+1][2];
   logic [QUOT_BITS-1:0]   quot_ff [NSTG+1][2];
   logic [QUOT_BITS-1:0]   quot_in [NSTG+1][2];

   // integer bit at entry, then shift-subtract steps per stage
   always_comb begin
      logic [NUM_W-1:0]     r;
      logic [QUOT_BITS-1:0] q;
      logic [REM_W-1:0]     two;
      for (int l = 0; l < 2; l++) begin
         den_in[0][l] = in_den[l];
         if (in_num[l] >= in_den[l]) begin
            quot_in[0][l] = QUOT_BITS'(1);
            rem_in[0][l]  = in_num[l] - in_den[l];
         end else begin
            quot_in[0][l] = '0;
            rem_in[0][l]  = in_num[l];
         end
      end
      for (int s = 1; s <= NSTG; s++) begin
         for (int l = 0; l < 2; l++) begin
            r = rem_ff[s-1][l];
            q = quot_ff[s-1][l];
            for (int t = 0; t < DIV_PER_STAGE; t++) begin
               if ((s - 1) * DIV_PER_STAGE + t < FRAC_STEPS) begin
                  two = {r, 1'b0};
                  if (two >= {1'b0, den_ff[s-1][l]}) begin
                     r = NUM_W'(two - {1'b0, den_ff[s-1][l]});
                     q = {q[QUOT_BITS-2:0], 1'b1};
                  end else begin
                     r = two[NUM_W-1:0];
                     q = {q[QUOT_BITS-2:0], 1'b0};
                  end
               end
            end
            rem_in[s][l]  = r;
            quot_in[s][l] = q;
            den_in[s][l]  = den_ff[s-1][l];
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ce) begin
         valid_ff <= {valid_ff[NSTG-1:0], in_valid};
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (ce) begin
         ring_ff <= {ring_ff[NSTG-1:0], in_ring};
         for (int s = 0; s <= NSTG; s++) begin
            for (int l = 0; l < 2; l++) begin
               rem_ff[s][l]  <= rem_in[s][l];
               den_ff[s][l]  <= den_in[s][l];
               quot_ff[s][l] <= quot_in[s][l];
            end
         end
      end
   end

   assign out_valid   = valid_ff[NSTG];
   assign out_ring    = ring_ff[NSTG];
   assign out_quot[0] = quot_ff[NSTG][0];
   assign out_quot[1] = quot_ff[NSTG][1];

endmodule

[rtl/tvg_cordic.sv]
// ----------------------------------------------------------------------------
// tvg_cordic
// pipelined rotation-mode cordic, two lanes, phase in turns to cos and sin
// ----------------------------------------------------------------------------
module tvg_cordic #(
   parameter int TRIG_FRAC_BITS = tvg_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                ce,
   input  logic                                in_valid,
   input  tvg_pkg::tvg_side_type               in_side,
   input  logic [tvg_pkg::PHASE_BITS-1:0]      in_phase [2],
   output logic                                out_valid,
   output tvg_pkg::tvg_side_type               out_side,
   output logic signed [TRIG_FRAC_BITS+1:0]    out_cos [2],
   output logic signed [TRIG_FRAC_BITS+1:0]    out_sin [2]
);
   import tvg_pkg::*;

   localparam int TW   = TRIG_FRAC_BITS + 2;
   localparam int NSTG = (CORDIC_ITERS + CORDIC_PER_STAGE - 1) / CORDIC_PER_STAGE;
   localparam int SH   = CORDIC_FRAC - TRIG_FRAC_BITS;
   localparam logic signed [CORDIC_W-1:0] RND_HALF = CORDIC_W'(64'd1 << (SH - 1));
   localparam logic signed [CORDIC_W-1:0] LIM      = CORDIC_W'(64'd1 << TRIG_FRAC_BITS);

   logic [NSTG+1:0]             valid_ff;
   tvg_side_type                side_ff [NSTG+2];
   logic signed [CORDIC_W-1:0]  x_ff [NSTG+1][2];
   logic signed [CORDIC_W-1:0]  x_in [NSTG+1][2];
   logic signed [CORDIC_W-1:0]  y_ff [NSTG+1][2];
   logic signed [CORDIC_W-1:0]  y_in [NSTG+1][2];
   logic signed [CORDIC_W-1:0]  z_ff [NSTG+1][2];
   logic signed [CORDIC_W-1:0]  z_in [NSTG+1][2];
   logic [1:0]                  quad_ff [NSTG+1][2];
   logic [1:0]                  quad_in [NSTG+1][2];
   logic signed [TW-1:0]        cos_ff [2];
   logic signed [TW-1:0]        cos_in [2];
   logic signed [TW-1:0]        sin_ff [2];
   logic signed [TW-1:0]        sin_in [2];

   // quadrant split at entry, then micro-rotations per stage
   always_comb begin
      logic signed [CORDIC_W-1:0] x, y, z, dx, dy, atn;
      int                         kk;
      for (int l = 0; l < 2; l++) begin
         quad_in[0][l] = in_phase[l][PHASE_BITS-1:PHASE_BITS-2];
         x_in[0][l]    = CORDIC_X0;
         y_in[0][l]    = '0;
         z_in[0][l]    = $signed({{(CORDIC_W-CORDIC_FRAC){1'b0}},
                                  in_phase[l][CORDIC_FRAC-1:0]});
      end
      for (int s = 1; s <= NSTG; s++) begin
         for (int l = 0; l < 2; l++) begin
            x = x_ff[s-1][l];
            y = y_ff[s-1][l];
            z = z_ff[s-1][l];
            for (int t = 0; t < CORDIC_PER_STAGE; t++) begin
               kk = (s - 1) * CORDIC_PER_STAGE + t;
               if (kk < CORDIC_ITERS) begin
                  dx  = y >>> kk;
                  dy  = x >>> kk;
                  atn = $signed({{(CORDIC_W-CORDIC_FRAC){1'b0}}, ATAN_TURNS[kk]});
                  if (!z[CORDIC_W-1]) begin
                     x = x - dx;
                     y = y + dy;
                     z = z - atn;
                  end else begin
                     x = x + dx;
                     y = y - dy;
                     z = z + atn;
                  end
               end
            end
            x_in[s][l]    = x;
            y_in[s][l]    = y;
            z_in[s][l]    = z;
            quad_in[s][l] = quad_ff[s-1][l];
         end
      end
   end

   // round, clamp and fold the quadrant back in
   always_comb begin
      logic signed [CORDIC_W-1:0] cr, sr;
      logic signed [TW-1:0]       cx, sy;
      for (int l = 0; l < 2; l++) begin
         cr = (x_ff[NSTG][l] + RND_HALF) >>> SH;
         sr = (y_ff[NSTG][l] + RND_HALF) >>> SH;
         if (cr > LIM)       cr = LIM;
         else if (cr < -LIM) cr = -LIM;
         if (sr > LIM)       sr = LIM;
         else if (sr < -LIM) sr = -LIM;
         cx = cr[TW-1:0];
         sy = sr[TW-1:0];
         case (quad_ff[NSTG][l])
            2'd0: begin
               cos_in[l] = cx;
               sin_in[l] = sy;
            end
            2'd1: begin
               cos_in[l] = -sy;
               sin_in[l] = cx;
            end
            2'd2: begin
               cos_in[l] = -cx;
               sin_in[l] = -sy;
            end
            default: begin
               cos_in[l] = sy;
               sin_in[l] = -cx;
            end
         endcase
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ce) begin
         valid_ff <= {valid_ff[NSTG:0], in_valid};
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (ce) begin
         side_ff[0] <= in_side;
         for (int s = 1; s <= NSTG + 1; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         for (int s = 0; s <= NSTG; s++) begin
            for (int l = 0; l < 2; l++) begin
               x_ff[s][l]    <= x_in[s][l];
               y_ff[s][l]    <= y_in[s][l];
               z_ff[s][l]    <= z_in[s][l];
               quad_ff[s][l] <= quad_in[s][l];
            end
         end
         for (int l = 0; l < 2; l++) begin
            cos_ff[l] <= cos_in[l];
            sin_ff[l] <= sin_in[l];
         end
      end
   end

   assign out_valid  = valid_ff[NSTG+1];
   assign out_side   = side_ff[NSTG+1];
   assign out_cos[0] = cos_ff[0];
   assign out_cos[1] = cos_ff[1];
   assign out_sin[0] = sin_ff[0];
   assign out_sin[1] = sin_ff[1];

endmodule

[rtl/tvg_shade.sv]
// ----------------------------------------------------------------------------
// tvg_shade
// four-stage vertex assembly: tube products, ring radius and normals,
// ring products, then rounding and saturation of the positions
// ----------------------------------------------------------------------------
module tvg_shade #(
   parameter int TRIG_FRAC_BITS = tvg_pkg::TRIG_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 ce,
   input  logic                                 in_valid,
   input  tvg_pkg::tvg_side_type                in_side,
   input  logic signed [TRIG_FRAC_BITS+1:0]     in_cu,
   input  logic signed [TRIG_FRAC_BITS+1:0]     in_su,
   input  logic signed [TRIG_FRAC_BITS+1:0]     in_cv,
   input  logic signed [TRIG_FRAC_BITS+1:0]     in_sv,
   input  logic [tvg_pkg::RADIUS_BITS-1:0]      major_radius,
   input  logic [tvg_pkg::RADIUS_BITS-1:0]      minor_radius,
   output logic                                 out_valid,
   output logic                                 out_last,
   output tvg_pkg::tvg_vertex_type              out_vertex
);
   import tvg_pkg::*;

   localparam int TF    = TRIG_FRAC_BITS;
   localparam int TW    = TF + 2;
   localparam int PR_W  = RADIUS_BITS + 1 + TW;
   localparam int PT_W  = 2 * TW;
   localparam int RHO_W = RADIUS_BITS + TF + 2;
   localparam int PP_W  = RHO_W + TW;
   localparam int NY_W  = TW + NORM_FRAC;
   localparam logic signed [PR_W-1:0] PR_HALF = PR_W'(64'd1 << (TF - 1));
   localparam logic signed [PT_W-1:0] PT_HALF = PT_W'(64'd1 << (2 * TF - NORM_FRAC - 1));
   localparam logic signed [PP_W-1:0] PP_HALF = PP_W'(64'd1 << (2 * TF - 1));

   logic [3:0]               valid_ff;
   tvg_side_type             side_ff [4];

   // stage 1: products with the minor angle
   logic signed [PR_W-1:0]   prcv_ff, prsv_ff;
   logic signed [PT_W-1:0]   pcvcu_ff, pcvsu_ff;
   logic signed [TW-1:0]     cu1_ff, su1_ff, sv1_ff;
   logic [RADIUS_BITS-1:0]   rmaj1_ff;

   // stage 2: ring radius, tube height and normals
   logic signed [RHO_W-1:0]     rho_ff, rho_in;
   logic signed [TW-1:0]        cu2_ff, su2_ff;
   logic signed [POS_BITS-1:0]  py2_ff, py_in;
   logic signed [NORM_BITS-1:0] nx2_ff, nx_in, ny2_ff, ny_in, nz2_ff, nz_in;

   // stage 3: products with the major angle
   logic signed [PP_W-1:0]      px3_ff, pz3_ff;
   logic signed [POS_BITS-1:0]  py3_ff;
   logic signed [NORM_BITS-1:0] nx3_ff, ny3_ff, nz3_ff;

   // stage 4: output vertex
   tvg_vertex_type              vert_ff, vert_in;

   // ring radius, tube height, normals with half-up rounding
   always_comb begin
      logic signed [PR_W-1:0] pr;
      logic signed [PT_W-1:0] tx, tz;
      logic signed [NY_W-1:0] ny;
      rho_in = $signed({2'b00, rmaj1_ff, {TF{1'b0}}}) + RHO_W'(prcv_ff);
      pr     = (prsv_ff + PR_HALF) >>> TF;
      py_in  = sat_pos(64'(pr));
      tx     = (pcvcu_ff + PT_HALF) >>> (2 * TF - NORM_FRAC);
      tz     = (pcvsu_ff + PT_HALF) >>> (2 * TF - NORM_FRAC);
      nx_in  = sat_norm(64'(tx));
      nz_in  = sat_norm(64'(tz));
      if (TF > NORM_FRAC) begin
         ny = (NY_W'(sv1_ff) + NY_W'(64'd1 << (TF - NORM_FRAC - 1))) >>> (TF - NORM_FRAC);
      end else begin
         ny = NY_W'(sv1_ff) <<< (NORM_FRAC - TF);
      end
      ny_in = sat_norm(64'(ny));
   end

   // final positions
   always_comb begin
      logic signed [PP_W-1:0] rx, rz;
      rx = (px3_ff + PP_HALF) >>> (2 * TF);
      rz = (pz3_ff + PP_HALF) >>> (2 * TF);
      vert_in.pos_x  = sat_pos(64'(rx));
      vert_in.pos_y  = py3_ff;
      vert_in.pos_z  = sat_pos(64'(rz));
      vert_in.norm_x = nx3_ff;
      vert_in.norm_y = ny3_ff;
      vert_in.norm_z = nz3_ff;
      vert_in.tex_s  = side_ff[2].tex_s;
      vert_in.tex_t  = side_ff[2].tex_t;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ce) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (ce) begin
         side_ff[0] <= in_side;
         side_ff[1] <= side_ff[0];
         side_ff[2] <= side_ff[1];
         side_ff[3] <= side_ff[2];
         prcv_ff    <= $signed({1'b0, minor_radius}) * in_cv;
         prsv_ff    <= $signed({1'b0, minor_radius}) * in_sv;
         pcvcu_ff   <= in_cv * in_cu;
         pcvsu_ff   <= in_cv * in_su;
         cu1_ff     <= in_cu;
         su1_ff     <= in_su;
         sv1_ff     <= in_sv;
         rmaj1_ff   <= major_radius;
         rho_ff     <= rho_in;
         cu2_ff     <= cu1_ff;
         su2_ff     <= su1_ff;
         py2_ff     <= py_in;
         nx2_ff     <= nx_in;
         ny2_ff     <= ny_in;
         nz2_ff     <= nz_in;
         px3_ff     <= rho_ff * cu2_ff;
         pz3_ff     <= rho_ff * su2_ff;
         py3_ff     <= py2_ff;
         nx3_ff     <= nx2_ff;
         ny3_ff     <= ny2_ff;
         nz3_ff     <= nz2_ff;
         vert_ff    <= vert_in;
      end
   end

   assign out_valid  = valid_ff[3];
   assign out_last   = side_ff[3].second_vertex;
   assign out_vertex = vert_ff;

endmodule

[tb/torus_vertex_generator_unit_test.sv]
// ----------------------------------------------------------------------------
// torus_vertex_generator_unit_test
// checks each grid point against a local fixed-point model of the torus
// tessellation: two vertices per point, ring 1 marked by tlast, with random
// gaps on both channels and register settings changed between phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module torus_vertex_generator_unit_test;
   import tvg_pkg::*;

   localparam int IDX_W      = 12;
   localparam int REQ_W      = ((2*IDX_W+8)/8)*8;
   localparam int CSR_W      = 16;
   localparam int WATCHDOG   = 20000;
   localparam int DRAIN_WAIT = 60;

   // expected vertex with its ring flag
   typedef struct {
      tvg_vertex_type vtx;
      logic           last;
   } vertex_exp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_W-1:0]      csr_data = '0;

   torus_vertex_generator_unit dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // model copy of the registers
   longint unsigned seg_major, seg_minor, rad_major, rad_minor;
   vertex_exp_type  vertex_queue[$];
   int              error_count = 0;
   int              vertex_count = 0;
   int              point_count = 0;
   int              idle_cycles = 0;
   bit              rsp_stall_long = 0;

   localparam longint ATAN_TBL[24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

   // rounding shift, half up
   function automatic longint round_shift(longint v, int s);
      if (s == 0) return v;
      return (v + (longint'(1) <<< (s-1))) >>> s;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint unsigned frac_of(longint unsigned k, longint unsigned d,
                                               int bits);
      return ((k << bits) + d / 2) / d;
   endfunction

   // rotation cordic on a fraction of a turn, Q1.14 outputs
   task automatic turn_sincos(input logic [31:0] phase, output longint c,
                              output longint s);
      longint x, y, z, dx, dy, cx, sy;
      x = 652032875; y = 0; z = phase[29:0];
      for (int k = 0; k < 24; k++) begin
         dx = y >>> k; dy = x >>> k;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN_TBL[k];
         end else begin
            x += dx; y -= dy; z += ATAN_TBL[k];
         end
      end
      cx = clip(round_shift(x, 16), -16384, 16384);
      sy = clip(round_shift(y, 16), -16384, 16384);
      case (phase[31:30])
         2'd0: begin c = cx;  s = sy;  end
         2'd1: begin c = -sy; s = cx;  end
         2'd2: begin c = -cx; s = -sy; end
         default: begin c = sy; s = -cx; end
      endcase
   endtask

   // expected vertex pair of one grid point
   task automatic predict_vertex_pair(input longint unsigned strip, input longint unsigned col);
      longint unsigned m, n, i, j, kk;
      longint cv, sv, cu, su, rho, py, ny;
      vertex_exp_type e;
      m = seg_major ? seg_major : 1;
      n = seg_minor ? seg_minor : 1;
      i = strip; j = col;
      if (i > m - 1) i = m - 1;
      if (j > n) j = n;
      turn_sincos(32'(frac_of(j, n, 32)), cv, sv);
      rho = longint'(rad_major << 14) + longint'(rad_minor) * cv;
      py = clip(round_shift(longint'(rad_minor) * sv, 14), -131072, 131071);
      ny = clip(sv, -16384, 16384);
      for (int ring = 0; ring < 2; ring++) begin
         kk = i + ring;
         turn_sincos(32'(frac_of(kk, m, 32)), cu, su);
         e.vtx.pos_x  = POS_BITS'(clip(round_shift(rho * cu, 28), -131072, 131071));
         e.vtx.pos_y  = POS_BITS'(py);
         e.vtx.pos_z  = POS_BITS'(clip(round_shift(rho * su, 28), -131072, 131071));
         e.vtx.norm_x = NORM_BITS'(clip(round_shift(cv * cu, 14), -16384, 16384));
         e.vtx.norm_y = NORM_BITS'(ny);
         e.vtx.norm_z = NORM_BITS'(clip(round_shift(cv * su, 14), -16384, 16384));
         e.vtx.tex_s  = TEX_BITS'(frac_of(kk, m, 16));
         e.vtx.tex_t  = TEX_BITS'(frac_of(j, n, 16));
         e.last = ring[0];
         vertex_queue.push_back(e);
      end
   endtask

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // send one grid point and queue its vertices; valid stays up after the
   // accepting edge so back-to-back points need no idle cycle
   task automatic send_point(input logic [IDX_W-1:0] strip, input logic [IDX_W:0] col,
                             input bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      repeat (g) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tdata  <= REQ_W'({col, strip});
      req_tvalid <= 1'b1;
      predict_vertex_pair(strip, col);
      point_count++;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // register write while the block is idle
   task automatic write_reg(input tvg_csr_index_type idx, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MAJOR_SEGMENTS: seg_major = value & 16'h1FFF;
         CSR_MINOR_SEGMENTS: seg_minor = value & 16'h1FFF;
         CSR_MAJOR_RADIUS:   rad_major = value;
         CSR_MINOR_RADIUS:   rad_minor = value;
         default: ;
      endcase
   endtask

   // drop the request valid and wait for all vertices to come back
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (vertex_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic set_all(input int m, input int n, input int rr, input int r);
      wait_idle();
      write_reg(CSR_MAJOR_SEGMENTS, CSR_W'(m));
      write_reg(CSR_MINOR_SEGMENTS, CSR_W'(n));
      write_reg(CSR_MAJOR_RADIUS, CSR_W'(rr));
      write_reg(CSR_MINOR_RADIUS, CSR_W'(r));
   endtask

   // extremes of both indices, clamping and wrap at the reset setting
   task automatic test_directed_indices();
      send_point(0, 0, 0);
      send_point(31, 16, 0);
      send_point(12'hFFF, 13'h1FFF, 0);
      send_point(7, 4, 0);
      send_point(16, 8, 1);
      send_point(12'hAAA, 13'h1555, 1);
      send_point(12'h555, 13'h0AAA, 1);
   endtask

   // zero counts act as one, largest counts and saturating radii
   task automatic test_register_extremes();
      set_all(0, 0, 512, 128);
      send_point(0, 0, 0);
      send_point(5, 3, 0);
      set_all(4096, 4096, 65535, 65535);
      send_point(0, 1024, 0);
      send_point(4095, 4096, 0);
      send_point(2048, 3072, 0);
      set_all(1, 1, 0, 0);
      send_point(0, 1, 0);
      set_all(3, 5, 16'h8000, 16'h7FFF);
      send_point(2, 5, 0);
      send_point(1, 2, 0);
      send_point(0, 4, 0);
   endtask

   // random points under random settings, mostly within range
   task automatic test_random_points();
      int m, n;
      logic [IDX_W-1:0] s;
      logic [IDX_W:0]   c;
      for (int phase_n = 0; phase_n < 7; phase_n++) begin
         m = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 64);
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 64);
         set_all(m, n, $urandom_range(0, 65535),
                 ($urandom_range(0, 1) ? $urandom_range(0, 1024) : $urandom_range(0, 65535)));
         for (int k = 0; k < 95; k++) begin
            if ($urandom_range(0, 9) < 8) begin
               s = $urandom_range(0, (m > 1 ? m : 1) - 1);
               c = $urandom_range(0, (n > 1 ? n : 1));
            end else begin
               s = $urandom; c = $urandom;
            end
            send_point(s, c, 1);
         end
      end
   endtask

   // receiver: random backpressure, long stalls switched on and off at random
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) rsp_stall_long <= ~rsp_stall_long;
      if (reset) rsp_tready <= 1'b0;
      else if (rsp_stall_long) rsp_tready <= ($urandom_range(0, 9) == 0);
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   // result check against the oldest expected vertex
   always @(posedge clock) begin
      vertex_exp_type e;
      tvg_vertex_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         vertex_count++;
         if (vertex_queue.size() == 0) begin
            $display("%0t: unexpected vertex %h", $time, rsp_tdata);
            error_count++;
         end else begin
            e = vertex_queue.pop_front();
            if (got.pos_x !== e.vtx.pos_x)
               $display("%0t: pos_x exp %0d got %0d", $time, e.vtx.pos_x, got.pos_x);
            if (got.pos_y !== e.vtx.pos_y)
               $display("%0t: pos_y exp %0d got %0d", $time, e.vtx.pos_y, got.pos_y);
            if (got.pos_z !== e.vtx.pos_z)
               $display("%0t: pos_z exp %0d got %0d", $time, e.vtx.pos_z, got.pos_z);
            if (got.norm_x !== e.vtx.norm_x)
               $display("%0t: norm_x exp %0d got %0d", $time, e.vtx.norm_x, got.norm_x);
            if (got.norm_y !== e.vtx.norm_y)
               $display("%0t: norm_y exp %0d got %0d", $time, e.vtx.norm_y, got.norm_y);
            if (got.norm_z !== e.vtx.norm_z)
               $display("%0t: norm_z exp %0d got %0d", $time, e.vtx.norm_z, got.norm_z);
            if (got.tex_s !== e.vtx.tex_s)
               $display("%0t: tex_s exp %0d got %0d", $time, e.vtx.tex_s, got.tex_s);
            if (got.tex_t !== e.vtx.tex_t)
               $display("%0t: tex_t exp %0d got %0d", $time, e.vtx.tex_t, got.tex_t);
            if (rsp_tlast !== e.last)
               $display("%0t: last exp %0b got %0b", $time, e.last, rsp_tlast);
            if (got !== e.vtx || rsp_tlast !== e.last) error_count++;
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("watchdog expired, %0d vertices outstanding", vertex_queue.size());
         $display("torus_vertex_generator_unit_test: errors");
         $finish;
      end
   end

   initial begin
      seg_major = 32; seg_minor = 16; rad_major = 512; rad_minor = 128;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_indices();
      test_register_extremes();
      test_random_points();
      wait_idle();
      $display("covered %0d grid points, %0d vertices checked, %0d bad",
               point_count, vertex_count, error_count);
      if (error_count == 0 && vertex_queue.size() == 0)
         $display("torus_vertex_generator_unit_test: clean");
      else
         $display("torus_vertex_generator_unit_test: errors");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/tvg_pkg.sv
rtl/tvg_divider.sv
rtl/tvg_cordic.sv
rtl/tvg_shade.sv
rtl/torus_vertex_generator_unit.sv
tb/torus_vertex_generator_unit_test.sv
